### rtl/fsi_pkg.sv
// ----------------------------------------------------------------------------
// fsi_pkg: shared types and control store for the filtered set intersection
// Holds field widths, filter mode codes, microcode word layout and the
// microcode program that sequences the datapath.
// ----------------------------------------------------------------------------
package fsi_pkg;

  // Default sizing of the survivor and incoming lists
  localparam int FSI_SET_CAPACITY = 32;
  localparam int FSI_VALUE_BITS   = 32;

  // Fixed widths of the channel fields
  localparam int DATA_W = 32;
  localparam int MODE_W = 2;

  // Filter mode codes
  localparam logic [MODE_W-1:0] MODE_EVEN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ODD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LETTER = 2'd2;

  // Datapath action selected by one microcode word
  typedef enum logic [3:0] {
    A_NONE      = 4'd0,
    A_ACCEPT    = 4'd1,
    A_M_INIT    = 4'd2,
    A_M_CMP     = 4'd3,
    A_M_DONE    = 4'd4,
    A_CLR_FIRST = 4'd5,
    A_E_INIT    = 4'd6,
    A_E_OUT     = 4'd7,
    A_E_EMPTY   = 4'd8,
    A_RUN_CLR   = 4'd9
  } act_t;

  // Jump condition of one microcode word
  typedef enum logic [3:0] {
    C_NEXT        = 4'd0,
    C_ALWAYS      = 4'd1,
    C_NOT_EOS     = 4'd2,
    C_FIRST       = 4'd3,
    C_MERGE_EMPTY = 4'd4,
    C_MORE_PAIRS  = 4'd5,
    C_NOT_EOA     = 4'd6,
    C_NO_SURV     = 4'd7,
    C_MORE_OUT    = 4'd8
  } cond_t;

  typedef logic [3:0] step_t;

  // Program step addresses
  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_SET_END   = 4'd1;
  localparam step_t S_M_INIT    = 4'd2;
  localparam step_t S_M_RD      = 4'd3;
  localparam step_t S_M_CMP     = 4'd4;
  localparam step_t S_M_DONE    = 4'd5;
  localparam step_t S_FIRST_END = 4'd6;
  localparam step_t S_E_INIT    = 4'd7;
  localparam step_t S_E_RD      = 4'd8;
  localparam step_t S_E_OUT     = 4'd9;
  localparam step_t S_E_END     = 4'd10;
  localparam step_t S_E_EMPTY   = 4'd11;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic hold;
    logic eos;
    logic first;
    logic eoa;
    logic merge_empty;
    logic more_pairs;
    logic no_surv;
    logic more_out;
  } fsi_stat_t;

  // Microcode program: one word per step, jump to target when cond holds
  function automatic uword_t ucode_rom(step_t pc);
    uword_t w;
    case (pc)
      S_IDLE:      w = '{A_ACCEPT,    C_NOT_EOS,     S_IDLE};
      S_SET_END:   w = '{A_NONE,      C_FIRST,       S_FIRST_END};
      S_M_INIT:    w = '{A_M_INIT,    C_MERGE_EMPTY, S_M_DONE};
      S_M_RD:      w = '{A_NONE,      C_NEXT,        S_IDLE};
      S_M_CMP:     w = '{A_M_CMP,     C_MORE_PAIRS,  S_M_RD};
      S_M_DONE:    w = '{A_M_DONE,    C_NEXT,        S_IDLE};
      S_FIRST_END: w = '{A_CLR_FIRST, C_NOT_EOA,     S_IDLE};
      S_E_INIT:    w = '{A_E_INIT,    C_NO_SURV,     S_E_EMPTY};
      S_E_RD:      w = '{A_NONE,      C_NEXT,        S_IDLE};
      S_E_OUT:     w = '{A_E_OUT,     C_MORE_OUT,    S_E_RD};
      S_E_END:     w = '{A_RUN_CLR,   C_ALWAYS,      S_IDLE};
      S_E_EMPTY:   w = '{A_E_EMPTY,   C_ALWAYS,      S_E_END};
      default:     w = '{A_RUN_CLR,   C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/fsi_if.sv
// ----------------------------------------------------------------------------
// fsi_if: channel interfaces of the filtered set intersection
// Element input, result output and filter mode write channels, each with
// valid/ready handshake and source/sink modports.
// ----------------------------------------------------------------------------
interface fsi_in_if;
  import fsi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     end_of_set;
  logic                     end_of_all;

  modport source(output valid, value, end_of_set, end_of_all, input ready);
  modport sink(input valid, value, end_of_set, end_of_all, output ready);
endinterface

interface fsi_out_if;
  import fsi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     result_valid;
  logic                     last_result;
  logic                     overflowed;

  modport source(output valid, result_value, result_valid, last_result, overflowed,
                 input ready);
  modport sink(input valid, result_value, result_valid, last_result, overflowed,
               output ready);
endinterface

interface fsi_cfg_if;
  import fsi_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] filter_mode;

  modport source(output valid, filter_mode, input ready);
  modport sink(input valid, filter_mode, output ready);
endinterface

### rtl/fsi_ram.sv
// ----------------------------------------------------------------------------
// fsi_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/fsi_sequencer.sv
// ----------------------------------------------------------------------------
// fsi_sequencer: microcode step counter
// Fetches one control word per step from the program table, holds while the
// datapath stalls, and advances or jumps on the word's condition.
// ----------------------------------------------------------------------------
module fsi_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  fsi_pkg::fsi_stat_t stat,
  output fsi_pkg::act_t      act
);
  import fsi_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  uword_t uw;
  logic   taken;

  // Fetch and evaluate the jump condition
  always_comb begin
    uw = ucode_rom(pc_r);
    case (uw.cond)
      C_NEXT:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NOT_EOS:     taken = !stat.eos;
      C_FIRST:       taken = stat.first;
      C_MERGE_EMPTY: taken = stat.merge_empty;
      C_MORE_PAIRS:  taken = stat.more_pairs;
      C_NOT_EOA:     taken = !stat.eoa;
      C_NO_SURV:     taken = stat.no_surv;
      C_MORE_OUT:    taken = stat.more_out;
      default:       taken = 1'b0;
    endcase
  end

  // Hold on stall, else jump or advance
  always_comb begin
    if (stat.hold) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign act = uw.act;

endmodule

### rtl/fsi_datapath.sv
// ----------------------------------------------------------------------------
// fsi_datapath: filter, list stores, merge compare and result register
// Carries out the action chosen by the sequencer each cycle and reports the
// flags that its jumps test. Survivors live in two banks used ping-pong.
// ----------------------------------------------------------------------------
module fsi_datapath #(
  parameter int SET_CAPACITY = fsi_pkg::FSI_SET_CAPACITY,
  parameter int VALUE_BITS   = fsi_pkg::FSI_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  fsi_in_if.sink             in_bus,
  fsi_out_if.source          out_bus,
  fsi_cfg_if.sink            cfg_bus,
  input  fsi_pkg::act_t      act,
  output fsi_pkg::fsi_stat_t stat
);
  import fsi_pkg::*;

  localparam int AW = $clog2(SET_CAPACITY);
  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

  // Control state
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CW-1:0]     sc_r, sc_nxt;
  logic [CW-1:0]     ic_r, ic_nxt;
  logic [CW-1:0]     mc_r, mc_nxt;
  logic [AW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic              bank_r, bank_nxt;
  logic              first_r, first_nxt;
  logic              ovf_r, ovf_nxt;
  logic              eoa_r, eoa_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Result payload
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_rvalid_r, out_rvalid_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  // Filter
  logic [VALUE_BITS-1:0] v_n;
  logic [7:0]            letter;
  logic                  pass;
  logic [VALUE_BITS-1:0] kept;

  // Store ports
  logic                  sw_en, sw_bank;
  logic [AW-1:0]         sw_addr;
  logic [VALUE_BITS-1:0] sw_data;
  logic                  iw_en;
  logic [AW-1:0]         iw_addr;
  logic [VALUE_BITS-1:0] a_rd, b_rd, inc_rd, surv_rd;

  logic [CW-1:0] i_x, j_x;
  logic          out_free;
  logic          last_pair_j;

  assign i_x         = CW'(i_r);
  assign j_x         = CW'(j_r);
  assign out_free    = !out_valid_r || out_bus.ready;
  assign last_pair_j = (j_x == ic_r - CW'(1));

  // Narrow the element and apply the filter
  always_comb begin
    v_n    = in_bus.value[VALUE_BITS-1:0];
    letter = v_n[7:0];
    pass   = 1'b0;
    kept   = v_n;
    case (mode_r)
      MODE_EVEN: begin
        pass = (v_n != '0) && !v_n[0];
      end
      MODE_ODD: begin
        pass = v_n[0];
      end
      MODE_LETTER: begin
        pass = letter inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        kept = VALUE_BITS'(letter);
      end
      default: begin
        pass = 1'b0;
      end
    endcase
  end

  // Flags for the sequencer
  always_comb begin
    stat.hold        = ((act == A_ACCEPT) && !in_bus.valid) ||
                       (((act == A_E_OUT) || (act == A_E_EMPTY)) && !out_free);
    stat.eos         = in_bus.end_of_set;
    stat.first       = first_r;
    stat.eoa         = eoa_r;
    stat.merge_empty = (sc_r == '0) || (ic_r == '0);
    stat.more_pairs  = !((i_x == sc_r - CW'(1)) && last_pair_j);
    stat.no_surv     = (sc_r == '0);
    stat.more_out    = (i_x != sc_r - CW'(1));
  end

  assign in_bus.ready  = (act == A_ACCEPT);
  assign cfg_bus.ready = 1'b1;
  assign surv_rd       = bank_r ? b_rd : a_rd;

  // Next state per action
  always_comb begin
    mode_nxt       = mode_r;
    sc_nxt         = sc_r;
    ic_nxt         = ic_r;
    mc_nxt         = mc_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    bank_nxt       = bank_r;
    first_nxt      = first_r;
    ovf_nxt        = ovf_r;
    eoa_nxt        = eoa_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_value_nxt  = out_value_r;
    out_rvalid_nxt = out_rvalid_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    sw_en          = 1'b0;
    sw_bank        = bank_r;
    sw_addr        = sc_r[AW-1:0];
    sw_data        = kept;
    iw_en          = 1'b0;
    iw_addr        = ic_r[AW-1:0];

    if (cfg_bus.valid) begin
      mode_nxt = cfg_bus.filter_mode;
    end

    case (act)
      A_ACCEPT: begin
        // Append a survivor to the current list, flag when full
        if (in_bus.valid) begin
          eoa_nxt = in_bus.end_of_all;
          if (pass && first_r) begin
            if (sc_r < CAP) begin
              sw_en  = 1'b1;
              sc_nxt = sc_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (pass) begin
            if (ic_r < CAP) begin
              iw_en  = 1'b1;
              ic_nxt = ic_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      A_M_INIT: begin
        i_nxt  = '0;
        j_nxt  = '0;
        mc_nxt = '0;
      end
      A_M_CMP: begin
        // Append a match to the other bank, then step the pair indexes
        if (surv_rd == inc_rd) begin
          if (mc_r < CAP) begin
            sw_en   = 1'b1;
            sw_bank = !bank_r;
            sw_addr = mc_r[AW-1:0];
            sw_data = inc_rd;
            mc_nxt  = mc_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (last_pair_j) begin
          j_nxt = '0;
          i_nxt = i_r + AW'(1);
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      A_M_DONE: begin
        sc_nxt   = mc_r;
        ic_nxt   = '0;
        bank_nxt = !bank_r;
      end
      A_CLR_FIRST: begin
        first_nxt = 1'b0;
      end
      A_E_INIT: begin
        i_nxt = '0;
      end
      A_E_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = DATA_W'($signed(surv_rd));
          out_rvalid_nxt = 1'b1;
          out_last_nxt   = (i_x == sc_r - CW'(1));
          out_ovf_nxt    = ovf_r;
          i_nxt          = i_r + AW'(1);
        end
      end
      A_E_EMPTY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_rvalid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          out_ovf_nxt    = ovf_r;
        end
      end
      A_RUN_CLR: begin
        sc_nxt    = '0;
        ic_nxt    = '0;
        first_nxt = 1'b1;
        ovf_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_EVEN;
      sc_r        <= '0;
      ic_r        <= '0;
      mc_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      bank_r      <= 1'b0;
      first_r     <= 1'b1;
      ovf_r       <= 1'b0;
      eoa_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      sc_r        <= sc_nxt;
      ic_r        <= ic_nxt;
      mc_r        <= mc_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      bank_r      <= bank_nxt;
      first_r     <= first_nxt;
      ovf_r       <= ovf_nxt;
      eoa_r       <= eoa_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.result_value = out_value_r;
  assign out_bus.result_valid = out_rvalid_r;
  assign out_bus.last_result  = out_last_r;
  assign out_bus.overflowed   = out_ovf_r;

  // Survivor banks and incoming list
  fsi_ram #(.WIDTH(VALUE_BITS), .DEPTH(SET_CAPACITY)) u_bank_a (
    .clk   (clk),
    .we    (sw_en && !sw_bank),
    .waddr (sw_addr),
    .wdata (sw_data),
    .raddr (i_r),
    .rdata (a_rd)
  );

  fsi_ram #(.WIDTH(VALUE_BITS), .DEPTH(SET_CAPACITY)) u_bank_b (
    .clk   (clk),
    .we    (sw_en && sw_bank),
    .waddr (sw_addr),
    .wdata (sw_data),
    .raddr (i_r),
    .rdata (b_rd)
  );

  fsi_ram #(.WIDTH(VALUE_BITS), .DEPTH(SET_CAPACITY)) u_incoming (
    .clk   (clk),
    .we    (iw_en),
    .waddr (iw_addr),
    .wdata (kept),
    .raddr (j_r),
    .rdata (inc_rd)
  );

  // Checks
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (sc_r <= CAP) && (ic_r <= CAP) && (mc_r <= CAP))
    else $error("list count beyond capacity");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (act == A_M_CMP) |-> ((i_x < sc_r) && (j_x < ic_r)))
    else $error("merge compare outside stored lists");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (act == A_E_OUT) |-> (i_x < sc_r))
    else $error("emit index outside survivor list");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rvalid_r) |-> out_last_r)
    else $error("empty result not marked last");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (act == A_RUN_CLR) |=> (first_r && !ovf_r && (sc_r == '0)))
    else $error("run state not cleared at end of run");

endmodule

### rtl/filtered_set_intersection_unit.sv
// ----------------------------------------------------------------------------
// filtered_set_intersection_unit: filtered multiset intersection
// Filters incoming elements, intersects consecutive sets and streams out the
// surviving list at the end of each run.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one element per beat, with end_of_set on the last element of a
//             set and end_of_all alongside it on the final set.
//   out_bus : one result beat per surviving element; last_result marks the
//             final one. An empty intersection gives a single beat with
//             result_valid low. overflowed reports dropped entries.
//   cfg_bus : writes filter_mode (even, odd, letters); write it between runs.
// Sequence:
//   The end of the first set clears the first-set flag. The end of a later
//   set runs the merge: a single compare loop over the two list stores
//   steps through every survivor/incoming pair. At the run end the survivor
//   list streams out, or a single empty beat is sent for an empty
//   intersection. The result register frees the input side: a new run
//   starts while the last result waits.
// Reset clears the lists and sets filter_mode to even. A stalled receiver
// holds the result register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module filtered_set_intersection_unit #(
  parameter int SET_CAPACITY = fsi_pkg::FSI_SET_CAPACITY,
  parameter int VALUE_BITS   = fsi_pkg::FSI_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  fsi_in_if.sink    in_bus,
  fsi_out_if.source out_bus,
  fsi_cfg_if.sink   cfg_bus
);
  import fsi_pkg::*;

  act_t      act;
  fsi_stat_t stat;

  // Program sequencer
  fsi_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .act   (act)
  );

  // Datapath with list stores
  fsi_datapath #(
    .SET_CAPACITY (SET_CAPACITY),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus),
    .act     (act),
    .stat    (stat)
  );

endmodule
